// ----- hw/rtl/u8s_pkg.sv -----
package u8s_pkg;

  // Default depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Byte classes and fields
  localparam logic [1:0] CONT_TAG     = 2'b10;
  localparam logic [2:0] LEAD2_TAG    = 3'b110;
  localparam logic [3:0] LEAD3_TAG    = 4'b1110;
  localparam logic [4:0] LEAD4_TAG    = 5'b11110;
  localparam logic [7:0] LATIN1_HI    = 8'hC0;
  localparam logic [7:0] LATIN1_LO    = 8'h80;
  localparam logic [7:0] LOW6_MASK    = 8'h3F;

  // Sequence lengths
  localparam logic [2:0] LEN_IDLE = 3'd0;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  // Code point limits
  localparam logic [10:0] MIN_CP2   = 11'h080;
  localparam logic [15:0] MIN_CP3   = 16'h0800;
  localparam logic [15:0] SURR_LO   = 16'hD800;
  localparam logic [15:0] SURR_HI   = 16'hDFFF;
  localparam logic [20:0] MIN_CP4   = 21'h010000;
  localparam logic [20:0] MAX_CP4   = 21'h10FFFF;

  // One unit of work for the back end: up to four source bytes, emitted
  // either raw or each one converted as ISO-8859-1
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            conv;
    logic            eot;
  } job_t;

endpackage

// ----- hw/rtl/u8s_in_if.sv -----
interface u8s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

// ----- hw/rtl/u8s_out_if.sv -----
interface u8s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_end;

  modport source (output valid, output out_byte, output run_last, output text_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input text_end,
                  output ready);
endinterface

// ----- hw/rtl/u8s_front.sv -----
module u8s_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  u8s_in_if.sink        in_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output u8s_pkg::job_t q_job_o
);
  import u8s_pkg::*;

  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [2:0]      exp_q, exp_d;

  logic       accept;
  logic [7:0] b;
  logic       eot;
  logic       busy;
  logic       is_cont;
  logic [2:0] lead_len;
  logic [1:0] n;
  logic       complete;
  logic       seq_ok;
  logic [7:0] s1, s2;
  logic [10:0] cp2;
  logic [15:0] cp3;
  logic [20:0] cp4;
  job_t       job;

  assign b        = in_i.in_byte;
  assign eot      = in_i.end_of_text;
  assign in_i.ready = !q_full_i;
  assign accept   = in_i.valid && in_i.ready;
  assign busy     = (exp_q != LEN_IDLE);
  assign is_cont  = (b[7:6] == CONT_TAG);
  assign n        = busy ? cnt_q : 2'd0;
  assign complete = ({1'b0, cnt_q} + 3'd1 >= exp_q) || (cnt_q == 2'd3);

  // Classify a lead byte by its sequence length
  always_comb begin
    priority if (b[7:5] == LEAD2_TAG) begin
      lead_len = LEN_TWO;
    end else if (b[7:4] == LEAD3_TAG) begin
      lead_len = LEN_THREE;
    end else if (b[7:3] == LEAD4_TAG) begin
      lead_len = LEN_FOUR;
    end else begin
      lead_len = LEN_IDLE;
    end
  end

  // Assemble the code point of a completed sequence and check it
  assign s1  = (cnt_q == 2'd1) ? b : held_q[1];
  assign s2  = (cnt_q == 2'd2) ? b : held_q[2];
  assign cp2 = {held_q[0][4:0], b[5:0]};
  assign cp3 = {held_q[0][3:0], s1[5:0], b[5:0]};
  assign cp4 = {held_q[0][2:0], s1[5:0], s2[5:0], b[5:0]};

  always_comb begin
    unique case (exp_q)
      LEN_TWO:   seq_ok = (cp2 >= MIN_CP2);
      LEN_THREE: seq_ok = (cp3 >= MIN_CP3) && !((cp3 >= SURR_LO) && (cp3 <= SURR_HI));
      LEN_FOUR:  seq_ok = (cp4 >= MIN_CP4) && (cp4 <= MAX_CP4);
      default:   seq_ok = 1'b0;
    endcase
  end

  // Build the job: held bytes first, the new byte right after them
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      job.bytes[i] = (n == 2'(i)) ? b : held_q[i];
    end
    job.bytes[3] = b;
    job.eot      = eot;
    job.conv     = 1'b1;
    job.count    = {1'b0, n} + 3'd1;
    held_d       = held_q;
    cnt_d        = 2'd0;
    exp_d        = LEN_IDLE;

    if (busy && is_cont) begin
      if (complete) begin
        job.conv = !seq_ok;
      end else if (!eot) begin
        // hold the continuation byte, nothing to emit yet
        job.count = 3'd0;
        for (int i = 0; i < 3; i++) begin
          if (cnt_q == 2'(i)) begin
            held_d[i] = b;
          end
        end
        cnt_d = cnt_q + 2'd1;
        exp_d = exp_q;
      end
    end else if ((lead_len != LEN_IDLE) && !eot) begin
      // flush any broken sequence, then start holding the new lead
      job.count = {1'b0, n};
      held_d[0] = b;
      cnt_d     = 2'd1;
      exp_d     = lead_len;
    end
  end

  assign q_job_o  = job;
  assign q_push_o = accept && (job.count != 3'd0);

  // Advance the held sequence on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      exp_q <= LEN_IDLE;
    end else if (accept) begin
      cnt_q <= cnt_d;
      exp_q <= exp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

// ----- hw/rtl/u8s_queue.sv -----
module u8s_queue #(
  parameter int unsigned Depth = u8s_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  u8s_pkg::job_t job_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output u8s_pkg::job_t job_o
);
  import u8s_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] fill_q;
  logic            do_push, do_pop;

  assign full_o  = (fill_q == CntW'(Depth));
  assign valid_o = (fill_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign job_o   = mem_q[rd_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - CntW'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/u8s_back.sv -----
module u8s_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  u8s_pkg::job_t q_job_i,
  output logic          q_pop_o,
  u8s_out_if.source     out_o
);
  import u8s_pkg::*;

  logic [1:0] idx_q;
  logic       half_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       end_q;

  logic       can_load;
  logic       step;
  logic [7:0] cur;
  logic       conv;
  logic       final_byte;
  logic       byte_done;
  logic       job_done;
  logic [7:0] beat;

  assign can_load   = !valid_q || out_o.ready;
  assign step       = can_load && q_valid_i;
  assign cur        = q_job_i.bytes[idx_q];
  assign conv       = q_job_i.conv && cur[7];
  assign final_byte = ({1'b0, idx_q} + 3'd1 == q_job_i.count);
  assign byte_done  = !conv || half_q;
  assign job_done   = final_byte && byte_done;
  assign q_pop_o    = step && job_done;

  // Pick the beat: raw byte, or Latin-1 high then low half
  always_comb begin
    priority if (conv && !half_q) begin
      beat = LATIN1_HI | {6'd0, cur[7:6]};
    end else if (conv) begin
      beat = LATIN1_LO | (cur & LOW6_MASK);
    end else begin
      beat = cur;
    end
  end

  // Walk the job one beat at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      half_q  <= 1'b0;
      valid_q <= 1'b0;
    end else if (can_load) begin
      valid_q <= q_valid_i;
      if (q_valid_i) begin
        if (job_done) begin
          idx_q  <= 2'd0;
          half_q <= 1'b0;
        end else if (byte_done) begin
          idx_q  <= idx_q + 2'd1;
          half_q <= 1'b0;
        end else begin
          half_q <= 1'b1;
        end
      end
    end
  end

  // Hold the output beat until it is taken
  always_ff @(posedge clk_i) begin
    if (step) begin
      byte_q <= beat;
      last_q <= job_done;
      end_q  <= job_done && q_job_i.eot;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.out_byte = byte_q;
  assign out_o.run_last = last_q;
  assign out_o.text_end = end_q;

endmodule

// ----- hw/rtl/utf8_sanitize_latin1_fallback_unit.sv -----
// UTF-8 sanitizer with ISO-8859-1 fallback.
// in_i carries one raw text byte per beat plus an end-of-text flag; out_o
// carries one byte of valid UTF-8 per beat, with run_last on the last beat
// of each job and text_end on the last beat of the text.
// The front end decodes each byte combinationally against the held lead and
// continuation bytes and posts a job of up to four source bytes to a short
// queue; the back end expands the job one output beat per cycle while the
// receiver is ready, two beats for each byte that is converted as Latin-1.
// An input beat passes through the queue entry register and then the back
// end's output register. The front end takes one input beat per cycle while
// the queue has room; the output beat count per input byte (0 to 8) sets the
// sustained input rate, and Latin-1 text gives two output beats per byte.
// Reset clears the held sequence, the queue and the output valid flag.
// When the receiver stalls, the output beat holds, the queue fills and
// in_i.ready drops until room frees up.
module utf8_sanitize_latin1_fallback_unit #(
  parameter int unsigned QueueDepth = u8s_pkg::QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  u8s_in_if.sink    in_i,
  u8s_out_if.source out_o
);
  import u8s_pkg::*;

  logic q_push, q_full, q_valid, q_pop;
  job_t job_in, job_out;

  u8s_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_job_o  (job_in)
  );

  u8s_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (job_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .job_o   (job_out)
  );

  u8s_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_job_i   (job_out),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule
